>>> design/tav_pkg.sv
// Shared types, constants and the CORDIC angle table for the terrain aspect window.
// No dependencies; every other design file but tav_ram refers to it by scoped names.
package tav_pkg;

    localparam int EW  = 16;   // elevation sample width
    localparam int DW  = 19;   // Horn gradient width
    localparam int XYW = 48;   // CORDIC x/y width (gradient scaled by 2^24 plus gain)
    localparam int ZW  = 34;   // CORDIC angle width, units of 1e-7 degree
    localparam int AHW = 16;   // aspect output width
    localparam int XY_SCALE = 24;

    localparam int WQW = 27;   // (angle + half step) / 32
    localparam int PW  = 55;   // reciprocal product width
    localparam int RSHIFT = 39;
    localparam logic [27:0] RECIP = 28'd175921861;  // ceil(2^39 / 3125)

    localparam logic signed [ZW-1:0] DEG_90    = 34'sd900000000;
    localparam logic signed [ZW-1:0] DEG_180   = 34'sd1800000000;
    localparam logic signed [ZW-1:0] DEG_360   = 34'sd3600000000;
    localparam logic signed [ZW-1:0] HALF_STEP = 34'sd50000;

    localparam logic [AHW-1:0] FLAT_ASPECT = 16'd18000;
    localparam logic [AHW-1:0] FULL_TURN   = 16'd36000;

    localparam logic [10:0]        COLS_RST   = 11'd1024;
    localparam logic [15:0]        ROWS_RST   = 16'd1024;
    localparam logic signed [15:0] NODATA_RST = -16'sd9999;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam int CFG_IW = 2;
    typedef enum logic [CFG_IW-1:0] {
        CFG_GRID_COLS = 2'd0,
        CFG_GRID_ROWS = 2'd1,
        CFG_NODATA    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 valid;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 no_data;
        logic                 last;
    } t_grad;

    typedef struct packed {
        logic                  valid;
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
        logic                  flat;
        logic                  no_data;
        logic                  last;
    } t_cordic;

    function automatic logic signed [ZW-1:0] atan_e7(input int unsigned step);
        logic signed [ZW-1:0] a;
        case (step)
            0:       a = 34'sd450000000;
            1:       a = 34'sd265650512;
            2:       a = 34'sd140362435;
            3:       a = 34'sd71250163;
            4:       a = 34'sd35763344;
            5:       a = 34'sd17899106;
            6:       a = 34'sd8951737;
            7:       a = 34'sd4476142;
            8:       a = 34'sd2238105;
            9:       a = 34'sd1119057;
            10:      a = 34'sd559529;
            11:      a = 34'sd279765;
            12:      a = 34'sd139882;
            13:      a = 34'sd69941;
            14:      a = 34'sd34971;
            15:      a = 34'sd17485;
            16:      a = 34'sd8743;
            17:      a = 34'sd4371;
            18:      a = 34'sd2186;
            19:      a = 34'sd1093;
            20:      a = 34'sd546;
            21:      a = 34'sd273;
            22:      a = 34'sd137;
            23:      a = 34'sd68;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> design/tav_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tav_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tav_window.sv
// Front end: configuration registers, grid position counters, the row store holding
// two rows per word and the 3x3 window, producing one Horn gradient word per emitted cell.
// Depends on tav_pkg and tav_ram.
module tav_window #(
    parameter int MAX_COLS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tav_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    input  logic                       i_valid,
    input  logic                       i_command,
    input  logic signed [15:0]         i_elevation,
    input  logic                       i_adv,
    output tav_pkg::t_grad             o_grad
);

    localparam int AW       = $clog2(MAX_COLS);
    localparam int CMPW     = (AW > 11) ? AW : 11;
    localparam int COLS_CAP = (MAX_COLS < 2047) ? MAX_COLS : 2047;
    localparam int EW       = tav_pkg::EW;
    localparam int DW       = tav_pkg::DW;

    // configuration
    logic [10:0]          r_cols;
    logic [15:0]          r_rows;
    logic signed [EW-1:0] r_nodata;
    logic                 geo_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= tav_pkg::COLS_RST;
            r_rows   <= tav_pkg::ROWS_RST;
            r_nodata <= tav_pkg::NODATA_RST;
        end else if (i_cfg_we) begin
            unique case (tav_pkg::t_cfg_idx'(i_cfg_index))
                tav_pkg::CFG_GRID_COLS: r_cols   <= i_cfg_data[10:0];
                tav_pkg::CFG_GRID_ROWS: r_rows   <= i_cfg_data;
                tav_pkg::CFG_NODATA:    r_nodata <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        geo_wr = 1'b0;
        if (i_cfg_we) begin
            unique case (tav_pkg::t_cfg_idx'(i_cfg_index))
                tav_pkg::CFG_GRID_COLS: geo_wr = 1'b1;
                tav_pkg::CFG_GRID_ROWS: geo_wr = 1'b1;
                default:                geo_wr = 1'b0;
            endcase
        end
    end

    logic [10:0] cols_eff, cols_m1;
    logic [15:0] rows_eff;

    always_comb begin
        if (r_cols == 11'd0) begin
            cols_eff = 11'd1;
        end else if (r_cols > 11'(COLS_CAP)) begin
            cols_eff = 11'(COLS_CAP);
        end else begin
            cols_eff = r_cols;
        end
        rows_eff = (r_rows == 16'd0) ? 16'd1 : r_rows;
        cols_m1  = cols_eff - 11'd1;
    end

    // position counters
    logic [AW-1:0] r_in_col,  n_in_col;
    logic [16:0]   r_in_row,  n_in_row;
    logic [11:0]   r_lead,    n_lead;
    logic [AW-1:0] r_out_col, n_out_col;
    logic [15:0]   r_out_row, n_out_row;

    logic in_col_wrap, complete, emit, out_col_last, out_row_last, last, push;

    always_comb begin
        in_col_wrap  = CMPW'(r_in_col) == CMPW'(cols_m1);
        complete     = r_in_row >= {1'b0, rows_eff};
        emit         = r_lead >= (12'(cols_eff) + 12'd1);
        out_col_last = CMPW'(r_out_col) == CMPW'(cols_m1);
        out_row_last = r_out_row == (rows_eff - 16'd1);
        last         = out_col_last && out_row_last;
        push         = i_valid && i_adv
                       && (i_command == tav_pkg::CMD_SAMPLE || complete);
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_lead    = r_lead;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (geo_wr || (push && emit && last)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_lead    = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (push) begin
            n_in_col = in_col_wrap ? '0 : r_in_col + AW'(1);
            if (in_col_wrap && !complete) begin
                n_in_row = r_in_row + 17'd1;
            end
            if (emit) begin
                n_out_col = out_col_last ? '0 : r_out_col + AW'(1);
                if (out_col_last) begin
                    n_out_row = r_out_row + 16'd1;
                end
            end else begin
                n_lead = r_lead + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_lead    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_lead    <= n_lead;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // stage 1: row store read in flight
    logic                 r_s1_valid;
    logic signed [EW-1:0] r_s1_sample;
    logic [AW-1:0]        r_s1_col;
    logic                 r_s1_emit, r_s1_last;
    logic                 r_s1_ok_after, r_s1_ok_before, r_s1_ok_left, r_s1_ok_right;
    logic                 r_s1_byp;
    logic signed [EW-1:0] r_s1_bup, r_s1_bmid;

    logic [2*EW-1:0]      ram_rdata;
    logic signed [EW-1:0] up_eff, mid_eff, sample_in;

    assign up_eff    = r_s1_byp ? r_s1_bup  : ram_rdata[2*EW-1:EW];
    assign mid_eff   = r_s1_byp ? r_s1_bmid : ram_rdata[EW-1:0];
    assign sample_in = (i_command == tav_pkg::CMD_FLUSH || complete) ? '0 : i_elevation;

    tav_ram #(
        .WIDTH (2 * EW),
        .DEPTH (MAX_COLS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (i_adv && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata ({mid_eff, r_s1_sample}),
        .i_re    (i_adv),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_sample    <= sample_in;
            r_s1_col       <= r_in_col;
            r_s1_emit      <= emit;
            r_s1_last      <= last;
            r_s1_ok_after  <= !out_row_last;
            r_s1_ok_before <= r_out_row != 16'd0;
            r_s1_ok_left   <= r_out_col != '0;
            r_s1_ok_right  <= !out_col_last;
            // the store read misses a write to the same column in this cycle
            r_s1_byp       <= r_s1_valid && (r_s1_col == r_in_col);
            r_s1_bup       <= mid_eff;
            r_s1_bmid      <= r_s1_sample;
        end
    end

    // window shift
    logic signed [EW-1:0] r_win [9];

    always_ff @(posedge i_clk) begin
        if (i_adv && r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= r_s1_sample;
            r_win[5] <= mid_eff;
            r_win[8] <= up_eff;
        end
    end

    // stage 2: window holds this cell's neighborhood
    logic r_s2_valid, r_s2_last;
    logic r_s2_ok_after, r_s2_ok_before, r_s2_ok_left, r_s2_ok_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_last      <= r_s1_last;
            r_s2_ok_after  <= r_s1_ok_after;
            r_s2_ok_before <= r_s1_ok_before;
            r_s2_ok_left   <= r_s1_ok_left;
            r_s2_ok_right  <= r_s1_ok_right;
        end
    end

    logic signed [DW-1:0] vx [9];
    logic signed [DW-1:0] dx, dy;
    logic                 nd;

    always_comb begin
        logic ok;
        nd = r_win[4] == r_nodata;
        for (int k = 0; k < 9; k++) begin
            ok = 1'b1;
            if (k < 3)      ok = ok && r_s2_ok_after;
            if (k >= 6)     ok = ok && r_s2_ok_before;
            if (k % 3 == 0) ok = ok && r_s2_ok_left;
            if (k % 3 == 2) ok = ok && r_s2_ok_right;
            // substitute the centre for missing neighbors
            vx[k] = (ok && r_win[k] != r_nodata) ? DW'(r_win[k]) : DW'(r_win[4]);
        end
        dx = (vx[0] + (vx[3] <<< 1) + vx[6]) - (vx[2] + (vx[5] <<< 1) + vx[8]);
        dy = (vx[0] + (vx[1] <<< 1) + vx[2]) - (vx[6] + (vx[7] <<< 1) + vx[8]);
    end

    // stage 3: gradient word
    tav_pkg::t_grad r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (i_adv) begin
            r_s3.valid   <= r_s2_valid;
            r_s3.dx      <= dx;
            r_s3.dy      <= dy;
            r_s3.no_data <= nd;
            r_s3.last    <= r_s2_last;
        end
    end

    assign o_grad = r_s3;

endmodule

>>> design/tav_cordic_cell.sv
// One vectoring CORDIC cell: a floor-shift micro-rotation and angle update per word.
// Depends on tav_pkg.
module tav_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  tav_pkg::t_cordic i_cd,
    output tav_pkg::t_cordic o_cd
);

    localparam logic signed [tav_pkg::ZW-1:0] ANGLE = tav_pkg::atan_e7(STEP);

    tav_pkg::t_cordic r_cd, n_cd;
    logic signed [tav_pkg::XYW-1:0] xs, ys;

    always_comb begin
        xs   = i_cd.x >>> STEP;
        ys   = i_cd.y >>> STEP;
        n_cd = i_cd;
        // rotate toward the x axis
        if (!i_cd.y[tav_pkg::XYW-1]) begin
            n_cd.x = i_cd.x + ys;
            n_cd.y = i_cd.y - xs;
            n_cd.z = i_cd.z + ANGLE;
        end else begin
            n_cd.x = i_cd.x - ys;
            n_cd.y = i_cd.y + xs;
            n_cd.z = i_cd.z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd.valid <= 1'b0;
        end else if (i_adv) begin
            r_cd <= n_cd;
        end
    end

    assign o_cd = r_cd;

endmodule

>>> design/terrain_aspect_window.sv
// Top level of the terrain aspect window: front end, CORDIC cell chain and
// angle-to-hundredths conversion. Depends on tav_pkg, tav_window, tav_cordic_cell.
//
// Usage:
//  - Input channel (i_valid / o_stall): one word per grid cell, row by row; i_command
//    selects an elevation sample or a flush that drains one pending cell at grid end.
//  - Output channel (o_valid / i_stall): one aspect word per emitted cell, in
//    hundredths of a degree, with no-data and last-cell flags.
//  - Configuration (i_cfg_we / i_cfg_index / i_cfg_data): write grid_cols, grid_rows
//    and nodata_value while idle; a geometry write restarts the grid.
//  - Throughput: one word per cycle while the output channel is not stalled.
//  - Pipeline: a cell is emitted with the word that completes its window, i.e.
//    grid_cols + 1 words after its own sample, and then passes the row store
//    read, window, gradient, pre-rotation, one stage per CORDIC cell and three
//    conversion stages.
//  - Stall: the whole pipeline holds while the output word waits; o_stall rises in
//    the same cycle, and an output register parts the two sides.
//  - Reset: synchronous, active low; clears counters and valids and loads the
//    register defaults (1024 x 1024 grid, no-data -9999). Row stores need no clearing.
module terrain_aspect_window #(
    parameter int MAX_COLS     = 1024,
    parameter int CORDIC_STEPS = 18
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tav_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_command,
    input  logic signed [15:0]         i_elevation,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [15:0]                o_aspect_hundredths,
    output logic                       o_no_data,
    output logic                       o_last_cell
);

    localparam int XYW = tav_pkg::XYW;
    localparam int ZW  = tav_pkg::ZW;
    localparam int PW  = tav_pkg::PW;
    localparam int WQW = tav_pkg::WQW;

    logic r_out_valid;
    logic adv;

    // advance everything when the output word is free or being taken
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;

    tav_pkg::t_grad grad;

    tav_window #(
        .MAX_COLS (MAX_COLS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_elevation (i_elevation),
        .i_adv       (adv),
        .o_grad      (grad)
    );

    // pre-rotation: scale by 2^24 and fold the left half plane onto x >= 0
    tav_pkg::t_cordic r_pre, n_pre;
    logic signed [XYW-1:0] px, py;

    always_comb begin
        px = XYW'(grad.dx) <<< tav_pkg::XY_SCALE;
        py = XYW'(grad.dy) <<< tav_pkg::XY_SCALE;
        n_pre.valid   = grad.valid;
        n_pre.flat    = (grad.dx == '0) && (grad.dy == '0);
        n_pre.no_data = grad.no_data;
        n_pre.last    = grad.last;
        if (px[XYW-1]) begin
            n_pre.x = -px;
            n_pre.y = -py;
            n_pre.z = tav_pkg::DEG_180;
        end else begin
            n_pre.x = px;
            n_pre.y = py;
            n_pre.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else if (adv) begin
            r_pre <= n_pre;
        end
    end

    // CORDIC chain: one cell per micro-rotation
    tav_pkg::t_cordic cd [CORDIC_STEPS+1];
    assign cd[0] = r_pre;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        tav_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_cd    (cd[g]),
            .o_cd    (cd[g+1])
        );
    end

    // rotate by 90 degrees, wrap to one turn, add half a hundredth, drop the /32
    logic signed [ZW-1:0] t_ang, u_ang;
    logic [WQW-1:0]       w_div;

    always_comb begin
        t_ang = cd[CORDIC_STEPS].z + tav_pkg::DEG_90;
        if (t_ang[ZW-1]) begin
            t_ang = t_ang + tav_pkg::DEG_360;
        end else if (t_ang >= tav_pkg::DEG_360) begin
            t_ang = t_ang - tav_pkg::DEG_360;
        end
        u_ang = t_ang + tav_pkg::HALF_STEP;
        w_div = u_ang[WQW+4:5];
    end

    logic           r_p1_valid, r_p1_flat, r_p1_nd, r_p1_last;
    logic [WQW-1:0] r_p1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= cd[CORDIC_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_w    <= w_div;
            r_p1_flat <= cd[CORDIC_STEPS].flat;
            r_p1_nd   <= cd[CORDIC_STEPS].no_data;
            r_p1_last <= cd[CORDIC_STEPS].last;
        end
    end

    // divide by 3125 through the reciprocal
    logic          r_p2_valid, r_p2_flat, r_p2_nd, r_p2_last;
    logic [PW-1:0] r_p2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (adv) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_prod <= PW'(r_p1_w) * PW'(tav_pkg::RECIP);
            r_p2_flat <= r_p1_flat;
            r_p2_nd   <= r_p1_nd;
            r_p2_last <= r_p1_last;
        end
    end

    logic [15:0] hund, n_aspect;

    always_comb begin
        hund = r_p2_prod[tav_pkg::RSHIFT+15:tav_pkg::RSHIFT];
        if (r_p2_nd) begin
            n_aspect = '0;
        end else if (r_p2_flat) begin
            n_aspect = tav_pkg::FLAT_ASPECT;
        end else if (hund >= tav_pkg::FULL_TURN) begin
            n_aspect = '0;
        end else begin
            n_aspect = hund;
        end
    end

    // output register
    logic [15:0] r_aspect;
    logic        r_nd, r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_aspect <= n_aspect;
            r_nd     <= r_p2_nd;
            r_last   <= r_p2_last;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_aspect_hundredths = r_aspect;
    assign o_no_data           = r_nd;
    assign o_last_cell         = r_last;

endmodule
